@@ hdl/hslrgb_pkg.sv @@
package hslrgb_pkg;

  // Piece of the hue ramp that a wrapped hue falls into.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  // Hue offset of one color lane.
  typedef enum logic [1:0] {
    OFS_PLUS,
    OFS_NONE,
    OFS_MINUS
  } hue_ofs_e;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

@@ hdl/hsl_to_rgb_convert.sv @@
// HSL to RGB converter for pixel streams. Hue, saturation and lightness come in
// as unsigned Q0.16 fractions and are carried internally at FRAC_BITS fraction
// bits; red, green and blue leave as 8-bit values. The block takes one word per
// clock while the output is not stalled, and has four register stages: the
// lightness times saturation product and hue wrapping, the p and q levels, the
// per-channel ramp multiply, and the final scale by 255. A stall on the output
// holds the pipeline in place and back-pressures the input through the ready
// chain, so no word is lost or repeated.
module hsl_to_rgb_convert #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [15:0] lightness_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import hslrgb_pkg::*;

  logic [3:0]           valid_q;
  stage_en_t            en;
  logic [23:0]          hue_x, sat_x, light_x;
  logic [FRAC_BITS-1:0] hue_f, sat_f, light_f;
  logic [FRAC_BITS:0]   p_w, q_w, d_w;

  // A stage loads when it is empty or its word moves on.
  assign en.s4      = !valid_q[3] || out_ready_i;
  assign en.s3      = !valid_q[2] || en.s4;
  assign en.s2      = !valid_q[1] || en.s3;
  assign en.s1      = !valid_q[0] || en.s2;
  assign in_ready_o = en.s1;
  assign out_valid_o = valid_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en.s1) valid_q[0] <= in_valid_i;
      if (en.s2) valid_q[1] <= valid_q[0];
      if (en.s3) valid_q[2] <= valid_q[1];
      if (en.s4) valid_q[3] <= valid_q[2];
    end
  end

  // Move the Q0.16 inputs to FRAC_BITS, truncating.
  assign hue_x   = {hue_i, 8'h00} >> (24 - FRAC_BITS);
  assign sat_x   = {saturation_i, 8'h00} >> (24 - FRAC_BITS);
  assign light_x = {lightness_i, 8'h00} >> (24 - FRAC_BITS);
  assign hue_f   = hue_x[FRAC_BITS-1:0];
  assign sat_f   = sat_x[FRAC_BITS-1:0];
  assign light_f = light_x[FRAC_BITS-1:0];

  // Zero saturation needs no bypass: it gives p equal to q equal to lightness.
  hslrgb_pq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pq (
    .clk_i  (clk_i),
    .en_i   (en),
    .sat_i  (sat_f),
    .light_i(light_f),
    .p_o    (p_w),
    .q_o    (q_w),
    .d_o    (d_w)
  );

  hslrgb_lane #(
    .FRAC_BITS(FRAC_BITS),
    .HUE_OFS  (OFS_PLUS)
  ) u_red (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (hue_f),
    .p_i   (p_w),
    .q_i   (q_w),
    .d_i   (d_w),
    .chan_o(red_o)
  );

  hslrgb_lane #(
    .FRAC_BITS(FRAC_BITS),
    .HUE_OFS  (OFS_NONE)
  ) u_green (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (hue_f),
    .p_i   (p_w),
    .q_i   (q_w),
    .d_i   (d_w),
    .chan_o(green_o)
  );

  hslrgb_lane #(
    .FRAC_BITS(FRAC_BITS),
    .HUE_OFS  (OFS_MINUS)
  ) u_blue (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (hue_f),
    .p_i   (p_w),
    .q_i   (q_w),
    .d_i   (d_w),
    .chan_o(blue_o)
  );

  // Back-pressure reaches the input only when every stage holds a word.
  a_full_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q == 4'b1111)
  ) else $error("input blocked while pipeline has a free stage");

  // A word never waits behind an empty stage.
  a_word_advances: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && !valid_q[1]) |=> valid_q[1]
  ) else $error("word failed to advance into empty stage");

  // An empty output stage always lets the input through.
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input blocked with empty output stage");

endmodule

@@ hdl/hslrgb_pq.sv @@
module hslrgb_pq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  hslrgb_pkg::stage_en_t  en_i,
  input  logic [FRAC_BITS-1:0]   sat_i,
  input  logic [FRAC_BITS-1:0]   light_i,
  output logic [FRAC_BITS:0]     p_o,
  output logic [FRAC_BITS:0]     q_o,
  output logic [FRAC_BITS:0]     d_o
);
  import hslrgb_pkg::*;

  logic [2*FRAC_BITS-1:0] ls_prod;
  logic [FRAC_BITS-1:0]   l1_q, s1_q, ls1_q;
  logic [FRAC_BITS+1:0]   q_w, p_w, d_w, two_l;
  logic [FRAC_BITS:0]     p2_q, q2_q, d2_q;

  assign ls_prod = light_i * sat_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      l1_q  <= light_i;
      s1_q  <= sat_i;
      ls1_q <= ls_prod[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  // The top bit of lightness tells whether it lies below one half.
  always_comb begin
    two_l = {1'b0, l1_q, 1'b0};
    if (l1_q[FRAC_BITS-1]) begin
      q_w = {2'b00, l1_q} + {2'b00, s1_q} - {2'b00, ls1_q};
    end else begin
      q_w = {2'b00, l1_q} + {2'b00, ls1_q};
    end
    if (two_l < q_w) begin
      p_w = '0;
    end else begin
      p_w = two_l - q_w;
    end
    d_w = q_w - p_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p2_q <= p_w[FRAC_BITS:0];
      q2_q <= q_w[FRAC_BITS:0];
      d2_q <= d_w[FRAC_BITS:0];
    end
  end

  assign p_o = p2_q;
  assign q_o = q2_q;
  assign d_o = d2_q;

endmodule

@@ hdl/hslrgb_lane.sv @@
module hslrgb_lane #(
  parameter int FRAC_BITS = 16,
  parameter hslrgb_pkg::hue_ofs_e HUE_OFS = hslrgb_pkg::OFS_NONE
) (
  input  logic                   clk_i,
  input  hslrgb_pkg::stage_en_t  en_i,
  input  logic [FRAC_BITS-1:0]   hue_i,
  input  logic [FRAC_BITS:0]     p_i,
  input  logic [FRAC_BITS:0]     q_i,
  input  logic [FRAC_BITS:0]     d_i,
  output logic [7:0]             chan_o
);
  import hslrgb_pkg::*;

  localparam int W = FRAC_BITS + 4;
  localparam longint unsigned OneI = 64'd1 << FRAC_BITS;
  localparam longint unsigned ThirdI = (OneI + 64'd1) / 64'd3;
  localparam logic [W-1:0] ONE_W = W'(OneI);
  localparam logic [W-1:0] THIRD_W = W'(ThirdI);
  localparam logic [FRAC_BITS:0] ONE_N = (FRAC_BITS+1)'(OneI);

  logic [W-1:0]           h_w, t_w, v_w, two_v, three_v, six_v, m_w;
  seg_e                   seg_w;
  seg_e                   seg1_q, seg2_q, seg3_q;
  logic [FRAC_BITS:0]     m1_q, m2_q;
  logic [2*FRAC_BITS+1:0] prod;
  logic [FRAC_BITS:0]     ramp3_q, p3_q, q3_q;
  logic [FRAC_BITS+1:0]   c_w;
  logic [FRAC_BITS:0]     c_cl;
  logic [FRAC_BITS+8:0]   scaled;
  logic [7:0]             chan4_q;

  // Stage 1: offset and wrap the hue, then pick the ramp piece.
  always_comb begin
    h_w = W'(hue_i);
    t_w = h_w + THIRD_W;
    case (HUE_OFS)
      OFS_PLUS: begin
        v_w = (t_w > ONE_W) ? t_w - ONE_W : t_w;
      end
      OFS_MINUS: begin
        v_w = (h_w < THIRD_W) ? h_w + ONE_W - THIRD_W : h_w - THIRD_W;
      end
      default: begin
        v_w = h_w;
      end
    endcase
    two_v   = v_w << 1;
    three_v = two_v + v_w;
    six_v   = three_v << 1;
    if (six_v < ONE_W) begin
      seg_w = SEG_RISE;
      m_w   = six_v;
    end else if (two_v < ONE_W) begin
      seg_w = SEG_HIGH;
      m_w   = '0;
    end else if (three_v < (ONE_W << 1)) begin
      seg_w = SEG_FALL;
      m_w   = ((ONE_W << 1) - three_v) << 1;
    end else begin
      seg_w = SEG_LOW;
      m_w   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      seg1_q <= seg_w;
      m1_q   <= m_w[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      seg2_q <= seg1_q;
      m2_q   <= m1_q;
    end
  end

  // Stage 3: slope times position along the ramp.
  assign prod = d_i * m2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ramp3_q <= prod[2*FRAC_BITS:FRAC_BITS];
      seg3_q  <= seg2_q;
      p3_q    <= p_i;
      q3_q    <= q_i;
    end
  end

  // Stage 4: channel fraction, clamp to one, scale by 255.
  always_comb begin
    case (seg3_q) inside
      SEG_RISE, SEG_FALL: c_w = {1'b0, p3_q} + {1'b0, ramp3_q};
      SEG_HIGH:           c_w = {1'b0, q3_q};
      default:            c_w = {1'b0, p3_q};
    endcase
    c_cl   = (c_w > {1'b0, ONE_N}) ? ONE_N : c_w[FRAC_BITS:0];
    scaled = {c_cl, 8'h00} - (FRAC_BITS+9)'(c_cl);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      chan4_q <= scaled[FRAC_BITS+7:FRAC_BITS];
    end
  end

  assign chan_o = chan4_q;

endmodule
